// ===== rtl/ipsv_pkg.sv =====
package ipsv_pkg;

	// sector codes, sector 1 of the space vector hexagon is code zero
	typedef enum logic [2:0] {
		SEC_1 = 3'd0,
		SEC_2 = 3'd1,
		SEC_3 = 3'd2,
		SEC_4 = 3'd3,
		SEC_5 = 3'd4,
		SEC_6 = 3'd5
	} ipsv_sector_t;

	// classified item handed from the rotation front to the timing back
	typedef struct packed {
		logic signed [31:0] alpha;
		logic signed [31:0] b3;
		ipsv_sector_t       sector;
	} ipsv_cls_t;

	// queue handshake seen from the front and the back
	typedef struct packed {
		logic push;
		logic pop;
	} ipsv_qreq_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ipsv_qsts_t;

	// odd polynomial for sin over a quarter turn, q30
	localparam logic [30:0] CA1 = 31'd1686629713;
	localparam logic [30:0] CA3 = 31'd693598669;
	localparam logic [30:0] CA5 = 31'd85569306;
	localparam logic [30:0] CA7 = 31'd5026994;
	localparam logic [30:0] CA9 = 31'd172272;

	localparam logic signed [31:0] INV_SQRT3_Q30 = 32'sd619925131;

	localparam logic [15:0] QUARTER_TURN = 16'd16384;
	localparam logic [15:0] SINE_ONE     = 16'd16384;

endpackage

// ===== rtl/ipsv_sine.sv =====
module ipsv_sine
	import ipsv_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic [15:0]        phase,
	output logic signed [15:0] sine
);

	logic [14:0] r;
	logic [30:0] z;
	logic [61:0] zz;
	logic [48:0] p9;
	logic [61:0] p7, p5, p3, p1;

	logic [30:0] z_l1, z_l2, z_l3, z_l4, z_l5;
	logic [30:0] z2_l1, z2_l2, z2_l3, z2_l4;
	logic        neg_l1, neg_l2, neg_l3, neg_l4, neg_l5, neg_l6;
	logic [30:0] t_l2, t_l3, t_l4, t_l5;
	logic [30:0] s_l6;
	logic [31:0] rnd;
	logic [15:0] mag;

	// fold the phase into the first quarter
	assign r  = phase[14] ? 15'(17'd16384 - 17'(phase[13:0])) : {1'b0, phase[13:0]};
	assign z  = {r, 16'b0};
	assign zz = 62'(z) * 62'(z);

	assign p9 = 49'(z2_l1) * 49'(CA9);
	assign p7 = 62'(z2_l2) * 62'(t_l2);
	assign p5 = 62'(z2_l3) * 62'(t_l3);
	assign p3 = 62'(z2_l4) * 62'(t_l4);
	assign p1 = 62'(z_l5) * 62'(t_l5);

	assign rnd = 32'(s_l6) + 32'd32768;
	assign mag = (rnd[31:16] > SINE_ONE) ? SINE_ONE : rnd[31:16];

	always_ff @(posedge clk) begin
		if (en) begin
			z_l1   <= z;
			z2_l1  <= zz[60:30];
			neg_l1 <= phase[15];

			z_l2   <= z_l1;
			z2_l2  <= z2_l1;
			neg_l2 <= neg_l1;
			t_l2   <= CA7 - 31'(p9[48:30]);

			z_l3   <= z_l2;
			z2_l3  <= z2_l2;
			neg_l3 <= neg_l2;
			t_l3   <= CA5 - p7[60:30];

			z_l4   <= z_l3;
			z2_l4  <= z2_l3;
			neg_l4 <= neg_l3;
			t_l4   <= CA3 - p5[60:30];

			z_l5   <= z_l4;
			neg_l5 <= neg_l4;
			t_l5   <= CA1 - p3[60:30];

			neg_l6 <= neg_l5;
			s_l6   <= p1[60:30];

			sine   <= neg_l6 ? -signed'(mag) : signed'(mag);
		end
	end

endmodule

// ===== rtl/ipsv_front.sv =====
module ipsv_front
	import ipsv_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] volt_d,
	input  logic signed [15:0] volt_q,
	input  logic [15:0]        elec_angle,
	input  ipsv_qsts_t         q_sts,
	output logic               q_push,
	output ipsv_cls_t          q_data
);

	localparam int NF   = 15;
	localparam int DL   = 11;
	localparam int PBW  = $clog2(SINE_TABLE_DEPTH);
	localparam logic [32:0] DEPTH_V = 33'(SINE_TABLE_DEPTH);
	localparam logic [32:0] RECIP   = 33'((64'd1 << 32) / SINE_TABLE_DEPTH);

	logic [NF-1:0] vf_q;
	logic          adv;

	logic signed [15:0] dd_q [DL];
	logic signed [15:0] dq_q [DL];

	logic [32:0]     pa;
	logic [PBW-1:0]  p_s1;
	logic [31:0]     n_full;
	logic [64:0]     pr;
	logic [15:0]     qe_s2, qe_s3;
	logic [31:0]     n_s2, n_s3;
	logic [32:0]     pq_s3;
	logic [32:0]     rem;
	logic [15:0]     ph_s4;
	logic [15:0]     phc;

	logic signed [15:0] sn, cs;
	logic signed [31:0] pdc_s12, pqs_s12, pds_s12, pqc_s12;
	logic signed [31:0] alpha_s13, beta_s13;
	logic signed [31:0] alpha_s14;
	logic               bneg_s14;
	logic signed [62:0] pb_s14;
	logic signed [31:0] b3, nb3;
	ipsv_sector_t       sec;

	assign adv      = !vf_q[NF-1] || !q_sts.full;
	assign in_ready = adv;
	assign q_push   = vf_q[NF-1] && !q_sts.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vf_q <= '0;
		end else if (adv) begin
			vf_q <= {vf_q[NF-2:0], in_valid};
		end
	end

	// table index and its phase, phase = index * 65536 / depth via reciprocal
	assign pa     = 33'(elec_angle) * DEPTH_V;
	assign n_full = 32'({p_s1, 16'b0});
	assign pr     = 65'(n_full) * 65'(RECIP);
	assign rem    = 33'(n_s3) - pq_s3;
	assign phc    = ph_s4 + QUARTER_TURN;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1  <= pa[16 +: PBW];
			qe_s2 <= pr[32 +: 16];
			n_s2  <= n_full;
			qe_s3 <= qe_s2;
			n_s3  <= n_s2;
			pq_s3 <= 33'(qe_s2) * DEPTH_V;
			ph_s4 <= qe_s3 + 16'(rem >= DEPTH_V);
			dd_q[0] <= volt_d;
			dq_q[0] <= volt_q;
			for (int i = 1; i < DL; i++) begin
				dd_q[i] <= dd_q[i-1];
				dq_q[i] <= dq_q[i-1];
			end
		end
	end

	ipsv_sine u_sin (
		.clk   (clk),
		.en    (adv),
		.phase (ph_s4),
		.sine  (sn)
	);

	ipsv_sine u_cos (
		.clk   (clk),
		.en    (adv),
		.phase (phc),
		.sine  (cs)
	);

	// inverse park, then beta / sqrt3
	always_ff @(posedge clk) begin
		if (adv) begin
			pdc_s12   <= 32'(dd_q[DL-1]) * 32'(cs);
			pqs_s12   <= 32'(dq_q[DL-1]) * 32'(sn);
			pds_s12   <= 32'(dd_q[DL-1]) * 32'(sn);
			pqc_s12   <= 32'(dq_q[DL-1]) * 32'(cs);
			alpha_s13 <= pdc_s12 - pqs_s12;
			beta_s13  <= pds_s12 + pqc_s12;
			alpha_s14 <= alpha_s13;
			bneg_s14  <= beta_s13[31];
			pb_s14    <= 63'(beta_s13) * 63'(INV_SQRT3_Q30);
		end
	end

	assign b3  = 32'(pb_s14 >>> 30);
	assign nb3 = -b3;

	always_comb begin
		if (!bneg_s14) begin
			priority if (alpha_s14 > b3) sec = SEC_1;
			else if (alpha_s14 > nb3)    sec = SEC_2;
			else                         sec = SEC_3;
		end else begin
			priority if (alpha_s14 >= nb3) sec = SEC_6;
			else if (alpha_s14 > b3)       sec = SEC_5;
			else                           sec = SEC_4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_data.alpha  <= alpha_s14;
			q_data.b3     <= b3;
			q_data.sector <= sec;
		end
	end

endmodule

// ===== rtl/ipsv_queue.sv =====
module ipsv_queue
	import ipsv_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ipsv_qreq_t req,
	input  ipsv_cls_t  wr_data,
	output ipsv_qsts_t sts,
	output ipsv_cls_t  rd_data
);

	localparam int AW = $clog2(DEPTH);

	ipsv_cls_t    mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          do_push, do_pop;

	assign sts.full  = (cnt_q == (AW+1)'(DEPTH));
	assign sts.empty = (cnt_q == '0);
	assign do_push   = req.push && !sts.full;
	assign do_pop    = req.pop && !sts.empty;
	assign rd_data   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/ipsv_back.sv =====
module ipsv_back
	import ipsv_pkg::*;
#(
	parameter int PWM_PERIOD = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [15:0]  mod_index,
	input  ipsv_qsts_t   q_sts,
	output logic         q_pop,
	input  ipsv_cls_t    q_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [12:0]  compare_u,
	output logic [12:0]  compare_v,
	output logic [12:0]  compare_w,
	output logic [2:0]   sector_index,
	output logic         clamped
);

	localparam int NB = 7;
	localparam int PW = $clog2(PWM_PERIOD + 1) + 1;
	localparam int TW = 40 + PW;
	localparam logic signed [TW-1:0] PER_S  = TW'(PWM_PERIOD);
	localparam logic signed [TW-1:0] PER2_S = TW'(2 * PWM_PERIOD);
	localparam logic signed [TW-1:0] TOP_S  = TW'(PWM_PERIOD) <<< 27;
	localparam logic [12:0]          PER13  = 13'(PWM_PERIOD);

	logic [NB-1:0] vb_q;
	logic          adv;

	logic signed [32:0] a, b, u1, u2;
	logic signed [16:0] m_s;

	logic signed [32:0] u1_s1, u2_s1;
	logic signed [32:0] u1_s2, u2_s2;
	logic signed [33:0] us_s2;
	logic signed [49:0] pm1_s3, pm2_s3;
	logic signed [50:0] pms_s3;
	logic signed [36:0] zb;
	logic signed [TW-1:0] z_s4, a1_s4, a2_s4;
	logic signed [TW-1:0] t0_s5, t1_s5, ar_s5;
	logic signed [TW-1:0] t0_s6, t1_s6, t2_s6;
	ipsv_sector_t sec_s1, sec_s2, sec_s3, sec_s4, sec_s5, sec_s6;
	logic         odd_first;

	logic [12:0] c0, c1, c2;
	logic        k0, k1, k2;

	assign adv       = !vb_q[NB-1] || out_ready;
	assign q_pop     = adv && !q_sts.empty;
	assign out_valid = vb_q[NB-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vb_q <= '0;
		end else if (adv) begin
			vb_q <= {vb_q[NB-2:0], !q_sts.empty};
		end
	end

	// active vector components for the sector
	assign a = 33'(q_data.alpha);
	assign b = 33'(q_data.b3);

	always_comb begin
		unique case (q_data.sector)
			SEC_1: begin u1 = a - b;       u2 = b + b;       end
			SEC_2: begin u1 = a + b;       u2 = b - a;       end
			SEC_3: begin u1 = b + b;       u2 = -a - b;      end
			SEC_4: begin u1 = b - a;       u2 = -(b + b);    end
			SEC_5: begin u1 = -a - b;      u2 = a - b;       end
			default: begin u1 = -(b + b);  u2 = a + b;       end
		endcase
	end

	assign m_s = signed'({1'b0, mod_index});
	assign zb  = (37'sd1 <<< 26) - 37'(pms_s3 >>> 15);

	// sectors 1, 3 and 5 add the second vector first
	assign odd_first = (sec_s4 == SEC_1) || (sec_s4 == SEC_3) || (sec_s4 == SEC_5);

	always_ff @(posedge clk) begin
		if (adv) begin
			u1_s1  <= u1;
			u2_s1  <= u2;
			sec_s1 <= q_data.sector;

			u1_s2  <= u1_s1;
			u2_s2  <= u2_s1;
			us_s2  <= 34'(u1_s1) + 34'(u2_s1);
			sec_s2 <= sec_s1;

			pm1_s3 <= 50'(u1_s2) * 50'(m_s);
			pm2_s3 <= 50'(u2_s2) * 50'(m_s);
			pms_s3 <= 51'(us_s2) * 51'(m_s);
			sec_s3 <= sec_s2;

			z_s4   <= TW'(zb) * PER_S;
			a1_s4  <= TW'(pm1_s3 >>> 15) * PER2_S;
			a2_s4  <= TW'(pm2_s3 >>> 15) * PER2_S;
			sec_s4 <= sec_s3;

			t0_s5  <= z_s4;
			t1_s5  <= z_s4 + (odd_first ? a2_s4 : a1_s4);
			ar_s5  <= odd_first ? a1_s4 : a2_s4;
			sec_s5 <= sec_s4;

			t0_s6  <= t0_s5;
			t1_s6  <= t1_s5;
			t2_s6  <= t1_s5 + ar_s5;
			sec_s6 <= sec_s5;
		end
	end

	function automatic logic [13:0] to_count(input logic signed [TW-1:0] t);
		logic [13:0] r;
		if (t < 0) begin
			r = {1'b1, 13'd0};
		end else if (t > TOP_S) begin
			r = {1'b1, PER13};
		end else begin
			r = {1'b0, t[27 +: 13]};
		end
		return r;
	endfunction

	assign {k0, c0} = to_count(t0_s6);
	assign {k1, c1} = to_count(t1_s6);
	assign {k2, c2} = to_count(t2_s6);

	// times come in switching order, map them to the phases
	always_ff @(posedge clk) begin
		if (adv) begin
			clamped      <= k0 | k1 | k2;
			sector_index <= sec_s6;
			unique case (sec_s6)
				SEC_1: begin compare_w <= c0; compare_v <= c1; compare_u <= c2; end
				SEC_2: begin compare_w <= c0; compare_u <= c1; compare_v <= c2; end
				SEC_3: begin compare_u <= c0; compare_w <= c1; compare_v <= c2; end
				SEC_4: begin compare_u <= c0; compare_v <= c1; compare_w <= c2; end
				SEC_5: begin compare_v <= c0; compare_u <= c1; compare_w <= c2; end
				default: begin compare_v <= c0; compare_w <= c1; compare_u <= c2; end
			endcase
		end
	end

endmodule

// ===== rtl/inverse_park_svpwm_unit.sv =====
// throughput: one item per cycle; each of the two pipelines holds while its downstream is full
// a four-entry queue between the rotation front and the timing back lets each side stall alone
// reset: arst_n clears all valid bits and the queue at once, modulation index returns to 16384
module inverse_park_svpwm_unit
	import ipsv_pkg::*;
#(
	parameter int PWM_PERIOD       = 4096,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,     // modulation_index
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // volt_d, volt_q, elec_angle
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // compare_u, compare_v, compare_w, sector_index, zero fill
	output logic        m_axis_tuser   // clamped
);

	logic [15:0] mod_q;
	ipsv_qreq_t  q_req;
	ipsv_qsts_t  q_sts;
	ipsv_cls_t   q_wr, q_rd;
	logic        q_push, q_pop;

	logic [12:0] cmp_u, cmp_v, cmp_w;
	logic [2:0]  sec_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= 16'd16384;
		end else if (cfg_wen) begin
			mod_q <= cfg_wdata;
		end
	end

	ipsv_front #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.volt_d     (signed'(s_axis_tdata[15:0])),
		.volt_q     (signed'(s_axis_tdata[31:16])),
		.elec_angle (s_axis_tdata[47:32]),
		.q_sts      (q_sts),
		.q_push     (q_push),
		.q_data     (q_wr)
	);

	assign q_req = '{push: q_push, pop: q_pop};

	ipsv_queue #(
		.DEPTH (4)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (q_req),
		.wr_data (q_wr),
		.sts     (q_sts),
		.rd_data (q_rd)
	);

	ipsv_back #(
		.PWM_PERIOD (PWM_PERIOD)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.mod_index    (mod_q),
		.q_sts        (q_sts),
		.q_pop        (q_pop),
		.q_data       (q_rd),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.compare_u    (cmp_u),
		.compare_v    (cmp_v),
		.compare_w    (cmp_w),
		.sector_index (sec_idx),
		.clamped      (m_axis_tuser)
	);

	assign m_axis_tdata = {6'b0, sec_idx, cmp_w, cmp_v, cmp_u};

endmodule
